@@ design/rmd_pkg.sv @@
// shared constants and functions for the ripemd-128 digest block
// no dependencies
package rmd_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] f_bool(input logic [1:0] sel, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
        logic [31:0] r;
        unique case (sel)
            2'd0: r = x ^ y ^ z;
            2'd1: r = (x & y) | (~x & z);
            2'd2: r = (x | ~y) ^ z;
            default: r = (x & z) | (y & ~z);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] f_kl(input logic [1:0] rnd);
        logic [31:0] r;
        unique case (rnd)
            2'd0: r = 32'h00000000;
            2'd1: r = 32'h5a827999;
            2'd2: r = 32'h6ed9eba1;
            default: r = 32'h8f1bbcdc;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] f_kr(input logic [1:0] rnd);
        logic [31:0] r;
        unique case (rnd)
            2'd0: r = 32'h50a28be6;
            2'd1: r = 32'h5c4dd124;
            2'd2: r = 32'h6d703ef3;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    localparam logic [255:0] SEL_L = {
        4'd2,4'd6,4'd5,4'd14,4'd15,4'd7,4'd3,4'd13,4'd4,4'd12,4'd8,4'd0,4'd10,4'd11,4'd9,4'd1,
        4'd12,4'd5,4'd11,4'd13,4'd6,4'd0,4'd7,4'd2,4'd1,4'd8,4'd15,4'd9,4'd4,4'd14,4'd10,4'd3,
        4'd8,4'd11,4'd14,4'd2,4'd5,4'd9,4'd0,4'd12,4'd3,4'd15,4'd6,4'd10,4'd1,4'd13,4'd4,4'd7,
        4'd15,4'd14,4'd13,4'd12,4'd11,4'd10,4'd9,4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0};
    localparam logic [255:0] SEL_R = {
        4'd14,4'd10,4'd7,4'd9,4'd13,4'd2,4'd12,4'd5,4'd0,4'd15,4'd11,4'd3,4'd1,4'd4,4'd6,4'd8,
        4'd13,4'd4,4'd0,4'd10,4'd2,4'd12,4'd8,4'd11,4'd9,4'd6,4'd14,4'd7,4'd3,4'd1,4'd5,4'd15,
        4'd2,4'd1,4'd9,4'd4,4'd12,4'd8,4'd15,4'd14,4'd10,4'd5,4'd13,4'd0,4'd7,4'd3,4'd11,4'd6,
        4'd12,4'd3,4'd10,4'd1,4'd8,4'd15,4'd6,4'd13,4'd4,4'd11,4'd2,4'd9,4'd0,4'd7,4'd14,4'd5};
    localparam logic [255:0] ROT_L = {
        4'd12,4'd5,4'd6,4'd8,4'd6,4'd5,4'd14,4'd9,4'd8,4'd9,4'd15,4'd14,4'd15,4'd14,4'd12,4'd11,
        4'd5,4'd7,4'd12,4'd5,4'd6,4'd13,4'd8,4'd14,4'd15,4'd13,4'd9,4'd14,4'd7,4'd6,4'd13,4'd11,
        4'd12,4'd13,4'd7,4'd11,4'd9,4'd15,4'd12,4'd7,4'd15,4'd7,4'd9,4'd11,4'd13,4'd8,4'd6,4'd7,
        4'd8,4'd9,4'd7,4'd6,4'd15,4'd14,4'd13,4'd11,4'd9,4'd7,4'd8,4'd5,4'd12,4'd15,4'd14,4'd11};
    localparam logic [255:0] ROT_R = {
        4'd8,4'd15,4'd5,4'd12,4'd9,4'd12,4'd9,4'd6,4'd14,4'd6,4'd14,4'd14,4'd11,4'd8,4'd5,4'd15,
        4'd5,4'd7,4'd13,4'd13,4'd14,4'd5,4'd13,4'd12,4'd14,4'd6,4'd6,4'd8,4'd11,4'd15,4'd7,4'd9,
        4'd11,4'd13,4'd15,4'd6,4'd7,4'd12,4'd7,4'd7,4'd11,4'd9,4'd8,4'd12,4'd7,4'd15,4'd13,4'd9,
        4'd6,4'd12,4'd14,4'd14,4'd11,4'd8,4'd7,4'd7,4'd5,4'd15,4'd15,4'd13,4'd11,4'd9,4'd9,4'd8};

    function automatic logic [3:0] f_tab(input logic [255:0] t, input logic [5:0] s);
        return t[{s, 2'b00} +: 4];
    endfunction

    function automatic logic [31:0] f_rotl(input logic [31:0] v, input logic [3:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

    // step control passed from sequencer to the word store
    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [1:0] wlane;
        logic [7:0] wdata;
        logic [3:0] raddr_l;
        logic [3:0] raddr_r;
    } t_buf_ctl;

endpackage

@@ design/ripemd128_hash.sv @@
// ripemd-128 digest engine top level: byte intake, padding, compression, digest output
// depends on rmd_pkg and rmd_buf
//
// input channel: i_valid/o_ready with i_kind, i_data_byte. kind 0 adds one byte,
// kind 1 finishes the message. output channel: o_valid/i_ready, four items per
// finish (o_digest_word, o_word_index, o_last_word), word 0 first.
// a data byte is written straight into the buffer; the 64th byte of a block starts a
// compression (one step of both lines per cycle, reading message words from the
// registered read ports of the two-port buffer memory, plus fold). a finish writes
// padding one byte a cycle, then one or two compressions, then shows the four
// words, each held until taken. input is not taken while compressing, padding or
// emitting. reset (synchronous, active low) restores the initial chaining value
// and clears length and fill count; the buffer needs no clearing. a stalled
// receiver simply holds the current digest word.
module ripemd128_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]   r_state;
    logic [5:0]   r_fill;
    logic [60:0]  r_len;
    logic [6:0]   r_step;
    logic         r_fin;      // compression belongs to finish
    logic         r_lenblk;   // current padded block carries length
    logic [31:0]  r_h [4];
    logic [31:0]  r_a [8];
    logic [1:0]   r_oidx;

    rmd_pkg::t_buf_ctl w_ctl;
    logic [31:0] w_rd_l, w_rd_r;
    logic [63:0] w_bits;
    logic [7:0]  w_pad;
    logic        w_acc;
    logic [5:0]  w_cs;        // step whose words are now on read data
    logic [1:0]  w_rnd;
    logic [31:0] w_tl, w_tr;

    rmd_buf u_buf (.i_clk(i_clk), .i_ctl(w_ctl), .o_rd_l(w_rd_l), .o_rd_r(w_rd_r));

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_bits  = {r_len, 3'b000};

    always_comb begin
        if (r_fill == 6'd56 && r_lenblk) w_pad = w_bits[7:0];
        else if (r_fill[5:3] == 3'd7 && r_lenblk) w_pad = w_bits[{r_fill[2:0], 3'b000} +: 8];
        else w_pad = 8'h00;
    end

    always_comb begin
        w_ctl = '0;
        w_ctl.waddr = r_fill[5:2];
        w_ctl.wlane = r_fill[1:0];
        w_ctl.raddr_l = rmd_pkg::f_tab(rmd_pkg::SEL_L, r_step[5:0]);
        w_ctl.raddr_r = rmd_pkg::f_tab(rmd_pkg::SEL_R, r_step[5:0]);
        if (w_acc) begin
            w_ctl.we = 1'b1;
            w_ctl.wdata = i_kind ? rmd_pkg::PAD_BYTE : i_data_byte;
        end else if (r_state == S_PAD) begin
            w_ctl.we = 1'b1;
            w_ctl.wdata = w_pad;
        end
    end

    assign w_cs  = r_step[5:0] - 6'd1;
    assign w_rnd = w_cs[5:4];
    assign w_tl = rmd_pkg::f_rotl(r_a[0] + rmd_pkg::f_bool(w_rnd, r_a[1], r_a[2], r_a[3])
                  + w_rd_l + rmd_pkg::f_kl(w_rnd), rmd_pkg::f_tab(rmd_pkg::ROT_L, w_cs));
    assign w_tr = rmd_pkg::f_rotl(r_a[4] + rmd_pkg::f_bool(~w_rnd, r_a[5], r_a[6], r_a[7])
                  + w_rd_r + rmd_pkg::f_kr(w_rnd), rmd_pkg::f_tab(rmd_pkg::ROT_R, w_cs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_len <= '0;
            r_step <= '0;
            r_fin <= 1'b0;
            r_lenblk <= 1'b0;
            r_oidx <= '0;
            r_h[0] <= rmd_pkg::IV0; r_h[1] <= rmd_pkg::IV1;
            r_h[2] <= rmd_pkg::IV2; r_h[3] <= rmd_pkg::IV3;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_fill <= r_fill + 6'd1;
                        r_step <= '0;
                        if (!i_kind) begin
                            r_len <= r_len + 61'd1;
                            r_fin <= 1'b0;
                            if (r_fill == 6'd63) r_state <= S_COMP;
                        end else begin
                            r_fin <= 1'b1;
                            r_lenblk <= (r_fill < 6'd56);
                            r_state <= (r_fill == 6'd63) ? S_COMP : S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) r_state <= S_COMP;
                end
                S_COMP: begin
                    if (r_step == 7'd0) begin
                        for (int i = 0; i < 4; i++) begin
                            r_a[i] <= r_h[i];
                            r_a[i+4] <= r_h[i];
                        end
                    end else begin
                        r_a[0] <= r_a[3]; r_a[3] <= r_a[2]; r_a[2] <= r_a[1]; r_a[1] <= w_tl;
                        r_a[4] <= r_a[7]; r_a[7] <= r_a[6]; r_a[6] <= r_a[5]; r_a[5] <= w_tr;
                    end
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'd64) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_h[0] <= r_h[1] + r_a[2] + r_a[7];
                    r_h[1] <= r_h[2] + r_a[3] + r_a[4];
                    r_h[2] <= r_h[3] + r_a[0] + r_a[5];
                    r_h[3] <= r_h[0] + r_a[1] + r_a[6];
                    r_step <= '0;
                    if (!r_fin) r_state <= S_IDLE;
                    else if (!r_lenblk) begin
                        r_lenblk <= 1'b1;
                        r_state <= S_PAD;
                    end else begin
                        r_oidx <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_state <= S_IDLE;
                            r_fill <= '0;
                            r_len <= '0;
                            r_fin <= 1'b0;
                            r_h[0] <= rmd_pkg::IV0; r_h[1] <= rmd_pkg::IV1;
                            r_h[2] <= rmd_pkg::IV2; r_h[3] <= rmd_pkg::IV3;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index = r_oidx;
    assign o_last_word = (r_oidx == 2'd3);
endmodule

@@ design/rmd_buf.sv @@
// block buffer: 16 words x 32 bits, byte-lane write, two registered read ports
// depends on rmd_pkg
module rmd_buf (
    input  logic              i_clk,
    input  rmd_pkg::t_buf_ctl i_ctl,
    output logic [31:0]       o_rd_l,
    output logic [31:0]       o_rd_r
);
    logic [31:0] r_mem [16];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            unique case (i_ctl.wlane)
                2'd0: r_mem[i_ctl.waddr][7:0]   <= i_ctl.wdata;
                2'd1: r_mem[i_ctl.waddr][15:8]  <= i_ctl.wdata;
                2'd2: r_mem[i_ctl.waddr][23:16] <= i_ctl.wdata;
                default: r_mem[i_ctl.waddr][31:24] <= i_ctl.wdata;
            endcase
        end
        o_rd_l <= r_mem[i_ctl.raddr_l];
        o_rd_r <= r_mem[i_ctl.raddr_r];
    end
endmodule

@@ design/rmd_chk.sv @@
// port-level checks for the ripemd-128 digest block, bound to the top level
// depends on ripemd128_hash ports only
module rmd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [1:0]  o_word_index,
    input logic        o_last_word
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("input taken while emitting");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 2'd3))) else $error("last flag");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("stalled item changed");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=> o_valid &&
        o_word_index == $past(o_word_index) + 2'd1) else $error("word order");
endmodule

bind ripemd128_hash rmd_chk u_rmd_chk (.*);

@@ test/tb.sv @@
// testbench for ripemd128_hash: byte-serial ripemd-128 digest with valid/ready on both sides
// depends on rmd_pkg (initial chaining value, pad byte) and the ripemd128_hash rtl
module tb;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } t_digest_item;

    class t_digest_scoreboard;
        logic [31:0]  chain[4];
        logic [7:0]   block[64];
        int unsigned  fill;
        logic [60:0]  msg_len;
        t_digest_item pending[$];
        int unsigned  errors;

        // message word order, shift amounts and round constants of both lines
        int sel_l[64] = '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
                          7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
                          3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
                          1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2};
        int sel_r[64] = '{5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
                          6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
                          15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
                          8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14};
        int sh_l[64] = '{11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
                         7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
                         11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
                         11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12};
        int sh_r[64] = '{8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
                         9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
                         9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
                         15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8};
        logic [31:0] k_l[4] = '{32'h0, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc};
        logic [31:0] k_r[4] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h0};

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            chain = '{rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3};
            fill = 0;
            msg_len = '0;
        endfunction

        function logic [31:0] mix(int s, logic [31:0] x, logic [31:0] y, logic [31:0] z);
            case (s)
                0: return x ^ y ^ z;
                1: return (x & y) | (~x & z);
                2: return (x | ~y) ^ z;
                default: return (x & z) | (y & ~z);
            endcase
        endfunction

        function void line_round(ref logic [31:0] r[4], input int s, input logic [31:0] w,
                                 input logic [31:0] k, input int sh);
            logic [31:0] t;
            t = r[0] + mix(s, r[1], r[2], r[3]) + w + k;
            t = (t << sh) | (t >> (32 - sh));
            r[0] = r[3]; r[3] = r[2]; r[2] = r[1]; r[1] = t;
        endfunction

        function void fold_block();
            logic [31:0] w[16];
            logic [31:0] a[4];
            logic [31:0] b[4];
            logic [31:0] t;
            for (int i = 0; i < 16; i++)
                w[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
            a = chain;
            b = chain;
            for (int j = 0; j < 64; j++) begin
                line_round(a, j / 16, w[sel_l[j]], k_l[j / 16], sh_l[j]);
                line_round(b, 3 - j / 16, w[sel_r[j]], k_r[j / 16], sh_r[j]);
            end
            t        = chain[1] + a[2] + b[3];
            chain[1] = chain[2] + a[3] + b[0];
            chain[2] = chain[3] + a[0] + b[1];
            chain[3] = chain[0] + a[1] + b[2];
            chain[0] = t;
        endfunction

        function void note_item(logic kind, logic [7:0] b);
            int p;
            logic [63:0] bits;
            if (!kind) begin
                block[fill] = b;
                msg_len++;
                fill = (fill + 1) % 64;
                if (fill == 0) fold_block();
                return;
            end
            p = fill;
            block[p] = rmd_pkg::PAD_BYTE;
            p++;
            if (p > 56) begin
                for (; p < 64; p++) block[p] = 8'h00;
                fold_block();
                p = 0;
            end
            for (; p < 56; p++) block[p] = 8'h00;
            bits = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++) block[56+i] = bits[8*i +: 8];
            fold_block();
            for (int i = 0; i < 4; i++)
                pending.push_back('{word: chain[i], idx: 2'(i), last: (i == 3)});
            restart();
        endfunction

        function void check_word(logic [31:0] w, logic [1:0] idx, logic last);
            t_digest_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest item word=%h idx=%0d last=%0d",
                         $time, w, idx, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (w !== e.word) begin
                $display("%0t: digest word: expected %h, got %h", $time, e.word, w);
                errors++;
            end
            if (idx !== e.idx) begin
                $display("%0t: word index: expected %0d, got %0d", $time, e.idx, idx);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last word: expected %0d, got %0d", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_kind = 0;
    logic [7:0]  i_data_byte = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    ripemd128_hash DUT (.*);

    t_digest_scoreboard sb = new();
    int  idle_pct = 38;
    int  hold_off = 0;
    int  quiet = 0;
    localparam int QUIET_LIMIT = 20000;

    initial forever #5 i_clk = ~i_clk;

    // sender: one item, with random gaps before it; valid stays up for a following item
    task automatic send_item(logic kind, logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid     <= 0;
            i_kind      <= 1'($urandom_range(1));
            i_data_byte <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        i_valid     <= 1;
        i_kind      <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(kind, b);
    endtask

    task automatic send_message(int n, int mode);
        for (int i = 0; i < n; i++)
            send_item(0, mode == 0 ? 8'h00 : mode == 1 ? 8'hff : 8'($urandom_range(255)));
        send_item(1, 8'($urandom_range(255)));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid     <= 0;
        i_kind      <= 1'($urandom_range(1));
        i_data_byte <= 8'($urandom_range(255));
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_word(o_digest_word, o_word_index, o_last_word);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int total;
        int n;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // empty message, tail lengths around the padding boundary, full blocks
        send_message(0, 2);
        send_message(1, 0);
        send_message(3, 1);
        send_message(55, 2);
        send_message(56, 1);
        send_message(63, 0);
        send_message(64, 2);
        send_item(1, 8'hff);
        // finish straight after a finish
        send_item(1, 8'h00);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        send_message(5, 2);
        send_message(2, 2);
        send_message(0, 2);
        drain();

        // no idling for a stretch
        idle_pct = 0;
        send_message(70, 2);
        send_message(10, 2);
        drain();
        idle_pct = 38;

        total = 0;
        while (total < 160) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(140) : $urandom_range(60);
            send_message(n, 2);
            total += n + 1;
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ ripemd128_hash.f @@
design/rmd_pkg.sv
design/rmd_buf.sv
design/ripemd128_hash.sv
design/rmd_chk.sv
test/tb.sv
